FILE: src/qap9_pkg.sv
// ----------------------------------------------------------------------------
// qap9_pkg: shared types and constants of the nine-tap average pooling block
//
// Holds the configuration register map, the reset values of the registers
// and the fixed widths of the requantizing datapath.
// ----------------------------------------------------------------------------
package qap9_pkg;

  // Fixed field widths.
  localparam int BYTE_W   = 8;
  localparam int EIU_W    = 4;
  localparam int BIAS_W   = 32;
  localparam int MULT_W   = 24;
  localparam int SHIFT_W  = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Datapath widths: signed biased sum, its magnitude, the product and the
  // rounding width, which is wider than any shift amount.
  localparam int ACC_W   = 34;
  localparam int MAG_W   = 32;
  localparam int PROD_W  = MAG_W + MULT_W;
  localparam int ROUND_W = 2 ** SHIFT_W;
  // Rounded magnitudes are saturated to this many bits before the zero point.
  localparam int SAT_W   = 9;
  // Signed width of the value after the zero point has been added.
  localparam int VAL_W   = SAT_W + 2;

  typedef logic [BYTE_W-1:0] u8_t;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEMENTS_IN_USE = 4'd0,
    REG_INIT_BIAS       = 4'd1,
    REG_SCALE_MULT      = 4'd2,
    REG_SCALE_SHIFT     = 4'd3,
    REG_ZERO_POINT      = 4'd4,
    REG_OUT_MIN         = 4'd5,
    REG_OUT_MAX         = 4'd6,
    REG_PAD_VALUE       = 4'd7
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [EIU_W-1:0]   RST_ELEMENTS_IN_USE = 4'd9;
  localparam logic [BIAS_W-1:0]  RST_INIT_BIAS       = 32'd0;
  localparam logic [MULT_W-1:0]  RST_SCALE_MULT      = 24'd8388608;
  localparam logic [SHIFT_W-1:0] RST_SCALE_SHIFT     = 6'd23;
  localparam u8_t                RST_ZERO_POINT      = 8'd0;
  localparam u8_t                RST_OUT_MIN         = 8'd0;
  localparam u8_t                RST_OUT_MAX         = 8'd255;
  localparam u8_t                RST_PAD_VALUE       = 8'd0;

endpackage

FILE: src/quantized_avgpool_nine_tap_top.sv
// ----------------------------------------------------------------------------
// quantized_avgpool_nine_tap_top: requantizing nine-tap average pooling
//
// Sums the window taps of one channel (padding unused taps), adds a signed
// bias, scales by a mantissa and a rounding right shift (ties to even), adds
// the zero point and clamps the result to one output byte.
//
//   Channel  Direction  Transfer when            Payload
//   in_      slave      in_tvalid & in_tready    tdata: tap0..tap(TAP_COUNT-1)
//   out_     master     out_tvalid & out_tready  tdata: pooled_value
//   cfg_     slave      cfg_valid & cfg_ready    cfg_index, cfg_data
//
// One item is taken per cycle unless the output stalls with every stage full;
// each result passes through the seven register stages (tap sum, bias,
// magnitude, multiply, round, zero point, clamp) before it is presented.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults. A stall on the output fills bubbles first and then holds every
// stage in place; cfg_ready is always high.
// ----------------------------------------------------------------------------
module quantized_avgpool_nine_tap_top
  import qap9_pkg::*;
#(
  parameter int TAP_COUNT = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input stream.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [TAP_COUNT*BYTE_W-1:0] in_tdata,  // tap0 [7:0], tap1 [15:8], ... upwards
  // Result stream.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [BYTE_W-1:0]       out_tdata,     // pooled_value [7:0]
  // Configuration writes.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_W    = BYTE_W + $clog2(TAP_COUNT + 1);
  localparam int N_STAGES = 7;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [EIU_W-1:0]   elements_in_use_r;
  logic [BIAS_W-1:0]  init_bias_r;
  logic [MULT_W-1:0]  scale_mult_r;
  logic [SHIFT_W-1:0] scale_shift_r;
  u8_t                zero_point_r;
  u8_t                out_min_r;
  u8_t                out_max_r;
  u8_t                pad_value_r;

  assign cfg_ready = 1'b1;

  // Writes to an index beyond the register map are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elements_in_use_r <= RST_ELEMENTS_IN_USE;
      init_bias_r       <= RST_INIT_BIAS;
      scale_mult_r      <= RST_SCALE_MULT;
      scale_shift_r     <= RST_SCALE_SHIFT;
      zero_point_r      <= RST_ZERO_POINT;
      out_min_r         <= RST_OUT_MIN;
      out_max_r         <= RST_OUT_MAX;
      pad_value_r       <= RST_PAD_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ELEMENTS_IN_USE: elements_in_use_r <= cfg_data[EIU_W-1:0];
        REG_INIT_BIAS:       init_bias_r       <= cfg_data[BIAS_W-1:0];
        REG_SCALE_MULT:      scale_mult_r      <= cfg_data[MULT_W-1:0];
        REG_SCALE_SHIFT:     scale_shift_r     <= cfg_data[SHIFT_W-1:0];
        REG_ZERO_POINT:      zero_point_r      <= cfg_data[BYTE_W-1:0];
        REG_OUT_MIN:         out_min_r         <= cfg_data[BYTE_W-1:0];
        REG_OUT_MAX:         out_max_r         <= cfg_data[BYTE_W-1:0];
        REG_PAD_VALUE:       pad_value_r       <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: a stage loads when it is empty or the stage after it
  // is loading, so bubbles close up behind a stalled output.
  // --------------------------------------------------------------------------
  logic [N_STAGES-1:0] vld_r;
  logic [N_STAGES-1:0] rdy;
  logic [N_STAGES-1:0] vld_in;

  always_comb begin
    rdy[N_STAGES-1] = !vld_r[N_STAGES-1] || out_tready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign vld_in    = {vld_r[N_STAGES-2:0], in_tvalid};
  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < N_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: padding and tap sum. Tap zero is never padded.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] s1_sum_r, s1_sum_nxt;

  always_comb begin
    u8_t tap;
    s1_sum_nxt = '0;
    for (int i = 0; i < TAP_COUNT; i++) begin
      tap = in_tdata[i*BYTE_W +: BYTE_W];
      if (i != 0 && EIU_W'(i) >= elements_in_use_r) begin
        tap = pad_value_r;
      end
      s1_sum_nxt = s1_sum_nxt + SUM_W'(tap);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && vld_in[0]) begin
      s1_sum_r <= s1_sum_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: add the signed bias at full width, so the sum never wraps.
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] s2_acc_r, s2_acc_nxt;

  assign s2_acc_nxt = $signed({{(ACC_W-BIAS_W){init_bias_r[BIAS_W-1]}}, init_bias_r})
                    + $signed({{(ACC_W-SUM_W){1'b0}}, s1_sum_r});

  always_ff @(posedge clk) begin
    if (rdy[1] && vld_in[1]) begin
      s2_acc_r <= s2_acc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: split into sign and magnitude; rounding works on the magnitude.
  // --------------------------------------------------------------------------
  logic             s3_neg_r;
  logic [MAG_W-1:0] s3_mag_r;
  logic [ACC_W-1:0] s3_abs;

  assign s3_abs = s2_acc_r[ACC_W-1] ? ACC_W'(-s2_acc_r) : ACC_W'(s2_acc_r);

  always_ff @(posedge clk) begin
    if (rdy[2] && vld_in[2]) begin
      s3_neg_r <= s2_acc_r[ACC_W-1];
      s3_mag_r <= s3_abs[MAG_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: unsigned multiply by the scale mantissa.
  // --------------------------------------------------------------------------
  logic              s4_neg_r;
  logic [PROD_W-1:0] s4_prod_r;

  always_ff @(posedge clk) begin
    if (rdy[3] && vld_in[3]) begin
      s4_neg_r  <= s3_neg_r;
      s4_prod_r <= PROD_W'(s3_mag_r) * PROD_W'(scale_mult_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: right shift with round-half-to-even decision. Only the low bits
  // of the quotient and a flag for anything above them are kept.
  // --------------------------------------------------------------------------
  logic               s5_neg_r;
  logic               s5_big_r;
  logic               s5_rnd_r;
  logic [SAT_W-1:0]   s5_qlo_r;
  logic [ROUND_W-1:0] s5_ext, s5_q, s5_mask, s5_rem, s5_half;
  logic               s5_rnd;

  always_comb begin
    s5_ext  = {{(ROUND_W-PROD_W){1'b0}}, s4_prod_r};
    s5_q    = s5_ext >> scale_shift_r;
    s5_mask = (ROUND_W'(1) << scale_shift_r) - ROUND_W'(1);
    s5_rem  = s5_ext & s5_mask;
    s5_half = (scale_shift_r == '0) ? '0 : (ROUND_W'(1) << (scale_shift_r - SHIFT_W'(1)));
    s5_rnd  = (scale_shift_r != '0) &&
              ((s5_rem > s5_half) || ((s5_rem == s5_half) && s5_q[0]));
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && vld_in[4]) begin
      s5_neg_r <= s4_neg_r;
      s5_big_r <= |s5_q[ROUND_W-1:SAT_W];
      s5_rnd_r <= s5_rnd;
      s5_qlo_r <= s5_q[SAT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: finish rounding, saturate the magnitude (anything that large
  // clamps the same way), restore the sign and add the zero point.
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0] s6_val_r, s6_val_nxt;
  logic [SAT_W:0]          s6_inc;
  logic [SAT_W-1:0]        s6_sat;
  logic signed [VAL_W-1:0] s6_signed;

  always_comb begin
    s6_inc     = {1'b0, s5_qlo_r} + (SAT_W+1)'(s5_rnd_r);
    s6_sat     = (s5_big_r || s6_inc[SAT_W]) ? '1 : s6_inc[SAT_W-1:0];
    s6_signed  = $signed({2'b00, s6_sat});
    if (s5_neg_r) begin
      s6_signed = -s6_signed;
    end
    s6_val_nxt = s6_signed + $signed({{(VAL_W-BYTE_W){1'b0}}, zero_point_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[5] && vld_in[5]) begin
      s6_val_r <= s6_val_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: clamp, lower bound first, then upper bound; output register.
  // --------------------------------------------------------------------------
  u8_t                     out_data_r, out_data_nxt;
  logic signed [VAL_W-1:0] s7_min, s7_max, s7_val;

  always_comb begin
    s7_min = $signed({{(VAL_W-BYTE_W){1'b0}}, out_min_r});
    s7_max = $signed({{(VAL_W-BYTE_W){1'b0}}, out_max_r});
    s7_val = s6_val_r;
    if (s7_val < s7_min) begin
      s7_val = s7_min;
    end
    if (s7_val > s7_max) begin
      s7_val = s7_max;
    end
    out_data_nxt = s7_val[BYTE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[6] && vld_in[6]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = vld_r[N_STAGES-1];
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input back-pressure only when every stage is full and the output stalls.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r) && !out_tready)
    else $error("input stalled while the pipeline has a bubble");

  // The stage behind a stalled output keeps its item and value.
  a_hold_behind_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && vld_r[5] |=> vld_r[5] && $stable(s6_val_r))
    else $error("stage six lost or changed its item during an output stall");

  // Reset leaves the pipeline empty.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && (vld_r == '0))
    else $error("pipeline not empty after reset");

endmodule

FILE: tb/tb_quantized_avgpool_nine_tap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quantized_avgpool_nine_tap_top: self-checking bench for nine-tap pooling
//
// Streams windows of nine byte taps into the pooling block under a series of
// register settings. A tracker object works out the requantized byte of each
// window as it is accepted, and every result transfer is compared with the
// oldest outstanding byte. Both stream sides idle at random in varying
// proportions. Registers are changed only once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_quantized_avgpool_nine_tap_top;
  import qap9_pkg::*;

  localparam int TAPS        = 9;
  localparam int WIN_W       = TAPS * BYTE_W;
  localparam int UNMAPPED_LO = REG_PAD_VALUE + 1;
  localparam int UNMAPPED_HI = 2 ** CFG_IDX_W - 1;
  localparam int TAIL_CYCLES = 20;

  typedef logic [WIN_W-1:0] window_t;

  // One full register setting; upper bits beyond each field may carry junk.
  typedef struct {
    logic [CFG_DATA_W-1:0] eiu;
    logic [CFG_DATA_W-1:0] bias;
    logic [CFG_DATA_W-1:0] mult;
    logic [CFG_DATA_W-1:0] shift;
    logic [CFG_DATA_W-1:0] zp;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] pad;
  } pool_cfg_t;

  // Tracks the register file and the bytes still owed by the block.
  class pool_tracker;
    logic [EIU_W-1:0]   eiu;
    logic [BIAS_W-1:0]  bias;
    logic [MULT_W-1:0]  mult;
    logic [SHIFT_W-1:0] shift;
    u8_t                zp;
    u8_t                lo;
    u8_t                hi;
    u8_t                pad;
    u8_t                pending_bytes[$];
    int                 fault_count;

    function new();
      eiu         = RST_ELEMENTS_IN_USE;
      bias        = RST_INIT_BIAS;
      mult        = RST_SCALE_MULT;
      shift       = RST_SCALE_SHIFT;
      zp          = RST_ZERO_POINT;
      lo          = RST_OUT_MIN;
      hi          = RST_OUT_MAX;
      pad         = RST_PAD_VALUE;
      fault_count = 0;
    endfunction

    // Indexes outside the map leave every register untouched.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ELEMENTS_IN_USE: eiu   = d[EIU_W-1:0];
        REG_INIT_BIAS:       bias  = d[BIAS_W-1:0];
        REG_SCALE_MULT:      mult  = d[MULT_W-1:0];
        REG_SCALE_SHIFT:     shift = d[SHIFT_W-1:0];
        REG_ZERO_POINT:      zp    = d[BYTE_W-1:0];
        REG_OUT_MIN:         lo    = d[BYTE_W-1:0];
        REG_OUT_MAX:         hi    = d[BYTE_W-1:0];
        REG_PAD_VALUE:       pad   = d[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function u8_t requantize_window(window_t w);
      longint      acc;
      longint      prod;
      longint      rounded;
      longint      val;
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] half;
      logic        neg;
      u8_t         tap;
      acc = longint'($signed(bias));
      // Tap zero is always a real sample; later taps past the count are padded.
      for (int i = 0; i < TAPS; i++) begin
        tap = w[i*BYTE_W +: BYTE_W];
        if (i != 0 && i >= eiu) begin
          tap = pad;
        end
        acc += longint'(tap);
      end
      prod = acc * longint'(mult);
      neg  = prod < 0;
      mag  = neg ? -prod : prod;
      // Symmetric rounding of the magnitude, ties to the even quotient.
      if (shift == 0) begin
        quo = mag;
      end else begin
        quo  = mag >> shift;
        rem  = mag & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && quo[0])) begin
          quo = quo + 64'd1;
        end
      end
      rounded = neg ? -longint'(quo) : longint'(quo);
      val = rounded + longint'(zp);
      // Lower bound first, so a crossed pair yields the upper bound.
      if (val < longint'(lo)) begin
        val = longint'(lo);
      end
      if (val > longint'(hi)) begin
        val = longint'(hi);
      end
      return val[BYTE_W-1:0];
    endfunction

    function void take_window(window_t w);
      pending_bytes.push_back(requantize_window(w));
    endfunction

    function void match_byte(u8_t got);
      u8_t want;
      if (pending_bytes.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected pooled_value, expected none, actual %0d", $time, got);
      end else begin
        want = pending_bytes.pop_front();
        if (want !== got) begin
          fault_count++;
          $display("%0t: pooled_value mismatch, expected %0d, actual %0d",
                   $time, want, got);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  window_t               in_tdata;   // tap0 [7:0], tap1 [15:8], ... tap8 [71:64]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;  // pooled_value [7:0]
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  pool_tracker tracker = new();

  quantized_avgpool_nine_tap_top #(
    .TAP_COUNT (TAPS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Check every result transfer against the oldest outstanding byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_byte(out_tdata);
    end
  end

  function automatic window_t fill(u8_t b);
    window_t w;
    for (int i = 0; i < TAPS; i++) begin
      w[i*BYTE_W +: BYTE_W] = b;
    end
    return w;
  endfunction

  // Only tap zero is meaningful; the rest is noise that must be padded away.
  function automatic window_t lead_tap(u8_t b);
    window_t w;
    for (int i = 0; i < TAPS; i++) begin
      w[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
    end
    w[BYTE_W-1:0] = b;
    return w;
  endfunction

  function automatic window_t rand_window();
    window_t w;
    logic    rails;
    rails = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < TAPS; i++) begin
      if (rails) begin
        w[i*BYTE_W +: BYTE_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        w[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
      end
    end
    return w;
  endfunction

  function automatic pool_cfg_t mk_cfg(logic [CFG_DATA_W-1:0] eiu, logic [CFG_DATA_W-1:0] bias,
                                       logic [CFG_DATA_W-1:0] mult,
                                       logic [CFG_DATA_W-1:0] shift,
                                       logic [CFG_DATA_W-1:0] zp, logic [CFG_DATA_W-1:0] lo,
                                       logic [CFG_DATA_W-1:0] hi, logic [CFG_DATA_W-1:0] pad);
    pool_cfg_t c;
    c.eiu   = eiu;
    c.bias  = bias;
    c.mult  = mult;
    c.shift = shift;
    c.zp    = zp;
    c.lo    = lo;
    c.hi    = hi;
    c.pad   = pad;
    return c;
  endfunction

  // Half of the settings behave like a true average, a quarter have coarse
  // shifts that hit rounding ties, and a quarter have every bit random.
  function automatic pool_cfg_t rand_cfg();
    pool_cfg_t c;
    int        kind;
    int        n;
    int        sh;
    int        m;
    kind = $urandom_range(0, 3);
    if (kind == 0) begin
      c = mk_cfg($urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom());
    end else if (kind == 1) begin
      c = mk_cfg($urandom_range(0, 15), -$urandom_range(0, 2300), $urandom_range(0, 3),
                 $urandom_range(0, 4), 128, $urandom_range(0, 20),
                 $urandom_range(235, 255), $urandom_range(0, 255));
    end else begin
      n  = $urandom_range(1, TAPS);
      sh = $urandom_range(14, 23);
      m  = ((1 << sh) + n / 2) / n + $urandom_range(0, 64) - 32;
      c.eiu   = ($urandom() & ~32'hF) | n;
      c.bias  = $urandom_range(0, 1024) - 512;
      c.mult  = ($urandom() & ~32'hFF_FFFF) | m;
      c.shift = ($urandom() & ~32'h3F) | sh;
      c.zp    = ($urandom() & ~32'hFF) | $urandom_range(0, 128);
      c.lo    = ($urandom() & ~32'hFF) | $urandom_range(0, 40);
      c.hi    = ($urandom() & ~32'hFF) | $urandom_range(215, 255);
      c.pad   = $urandom();
    end
    return c;
  endfunction

  // Holds a register write until it transfers; the caller lowers cfg_valid.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, d);
  endtask

  // Writes the whole register file, then a stray write outside the map.
  task automatic apply_settings(input pool_cfg_t c);
    put_reg(REG_ELEMENTS_IN_USE, c.eiu);
    put_reg(REG_INIT_BIAS, c.bias);
    put_reg(REG_SCALE_MULT, c.mult);
    put_reg(REG_SCALE_SHIFT, c.shift);
    put_reg(REG_ZERO_POINT, c.zp);
    put_reg(REG_OUT_MIN, c.lo);
    put_reg(REG_OUT_MAX, c.hi);
    put_reg(REG_PAD_VALUE, c.pad);
    put_reg(CFG_IDX_W'($urandom_range(UNMAPPED_LO, UNMAPPED_HI)), $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Offers one window, with random idle cycles ahead of it.
  task automatic send_window(input window_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    tracker.take_window(w);
  endtask

  // Stops offering windows and waits until every owed byte has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending_bytes.size() != 0);
  endtask

  task automatic random_block(input int settings, input int items);
    for (int s = 0; s < settings; s++) begin
      apply_settings(rand_cfg());
      for (int k = 0; k < items; k++) begin
        // Let the pipeline also run dry halfway through each setting.
        if (k == items / 2) begin
          drain();
        end
        send_window(rand_window());
      end
      drain();
    end
  endtask

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ELEMENTS_IN_USE;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 30;
    rx_idle_pct = 74;

    // Register defaults: empty, full, alternating and 0x10 windows.
    send_window(fill(8'h00));
    send_window(fill(8'hFF));
    send_window(fill(8'h55));
    send_window(fill(8'hAA));
    send_window(fill(8'h10));
    drain();

    // Halving shift on a single tap: ties on both sides of zero.
    apply_settings(mk_cfg(1, -4, 1, 1, 128, 0, 255, 0));
    send_window(lead_tap(8'd1));
    send_window(lead_tap(8'd2));
    send_window(lead_tap(8'd3));
    send_window(lead_tap(8'd5));
    send_window(lead_tap(8'd7));
    drain();

    // Zero element count acts as one; most negative bias; widest shift.
    apply_settings(mk_cfg(0, 32'h8000_0000, 32'h00FF_FFFF, 63, 255, 0, 255, 255));
    send_window(fill(8'hFF));
    send_window(fill(8'h00));
    drain();

    // Count past nine, largest bias and scale, no shift, crossed clamp bounds.
    apply_settings(mk_cfg(15, 32'h7FFF_FFFF, 32'h00FF_FFFF, 0, 0, 200, 50, 0));
    send_window(fill(8'hFF));
    send_window(fill(8'h00));
    drain();

    // Zero mantissa leaves only the zero point.
    apply_settings(mk_cfg(10, 0, 0, 23, 77, 0, 255, 0));
    send_window(fill(8'd200));
    drain();

    // Strongly negative sum pinned at the lower bound.
    apply_settings(mk_cfg(5, -100000, 8388608, 23, 0, 3, 250, 128));
    send_window(fill(8'hFF));
    send_window(fill(8'd9));
    drain();

    random_block(4, 84);

    tx_idle_pct = 74;
    rx_idle_pct = 30;
    random_block(4, 84);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_block(4, 84);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fault_count == 0 && tracker.pending_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/qap9_pkg.sv
src/quantized_avgpool_nine_tap_top.sv
tb/tb_quantized_avgpool_nine_tap_top.sv
